[hw/rtl/csr_pkg.sv]
// Shared constants, types and the two-tap blend function of the chroma resampler.
package csr_pkg;

  // Sample and register field widths.
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned OFFSET_W      = 3;
  localparam int unsigned LINE_WIDTH_W  = 13;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 13;

  // Default depth of the line store.
  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;

  // Reset value of the line width register.
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 13'd960;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 2'd2;

  // Filter offsets as seen by the datapath.
  typedef struct packed {
    logic [OFFSET_W-1:0] offset_x;
    logic [OFFSET_W-1:0] offset_y;
  } csr_offsets_t;

  // One stored line entry: U in the low half, V in the high half.
  typedef struct packed {
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] u;
  } csr_pair_t;

  // Computes (k*older + (8-k)*newer + 4) >> 3. The result never exceeds the
  // larger operand, so it always fits in one sample.
  function automatic logic [SAMPLE_W-1:0] blend(
    input logic [SAMPLE_W-1:0] older,
    input logic [SAMPLE_W-1:0] newer,
    input logic [OFFSET_W-1:0] k
  );
    logic [19:0] acc;
    logic [3:0]  k_inv;
    k_inv = 4'd8 - {1'b0, k};
    acc   = 20'(k) * 20'(older) + 20'(k_inv) * 20'(newer) + 20'd4;
    return acc[18:3];
  endfunction

endpackage

[hw/rtl/csr_ifs.sv]
// Valid/ready channel interfaces of the chroma resampler: samples, results, configuration.
interface csr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] u_in;
  logic [15:0] v_in;
  logic        frame_start;

  modport source(output valid, output u_in, output v_in, output frame_start, input ready);
  modport sink(input valid, input u_in, input v_in, input frame_start, output ready);
endinterface

interface csr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] u_out;
  logic [15:0] v_out;

  modport source(output valid, output u_out, output v_out, input ready);
  modport sink(input valid, input u_out, input v_out, output ready);
endinterface

interface csr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[hw/rtl/csr_cfg_regs.sv]
// Configuration registers of the chroma resampler with the clamped line width.
module csr_cfg_regs #(
  parameter int unsigned MAX_LINE_WIDTH = csr_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned WW             = $clog2(MAX_LINE_WIDTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  csr_cfg_if.sink                cfg,
  output csr_pkg::csr_offsets_t  offsets,
  output logic [WW-1:0]          eff_width
);
  import csr_pkg::*;

  localparam int unsigned CW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;
  localparam logic [CW-1:0] MAX_W = CW'(MAX_LINE_WIDTH);

  logic [OFFSET_W-1:0]     offset_x;
  logic [OFFSET_W-1:0]     offset_y;
  logic [LINE_WIDTH_W-1:0] line_width;
  logic [CW-1:0]           width_ext;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      line_width <= LINE_WIDTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFFSET_X:   offset_x   <= cfg.data[OFFSET_W-1:0];
        REG_OFFSET_Y:   offset_y   <= cfg.data[OFFSET_W-1:0];
        REG_LINE_WIDTH: line_width <= cfg.data[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero width acts as one; widths beyond the store saturate.
  always_comb begin
    width_ext = CW'(line_width);
    if (width_ext == '0) begin
      eff_width = WW'(1);
    end else if (width_ext > MAX_W) begin
      eff_width = WW'(MAX_LINE_WIDTH);
    end else begin
      eff_width = width_ext[WW-1:0];
    end
  end

  assign offsets.offset_x = offset_x;
  assign offsets.offset_y = offset_y;

endmodule

[hw/rtl/csr_line_store.sv]
// Line store of horizontally filtered U/V pairs with a registered read.
module csr_line_store #(
  parameter int unsigned DEPTH = csr_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                en,
  input  logic [AW-1:0]       addr,
  input  csr_pkg::csr_pair_t  wdata,
  output csr_pkg::csr_pair_t  rdata
);
  import csr_pkg::*;

  csr_pair_t mem [DEPTH];

  // Read and write share one address; the read returns the entry from the
  // line above, before this beat overwrites it.
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata     <= mem[addr];
    end
  end

endmodule

[hw/rtl/chroma_siting_resampler.sv]
// Top level of the chroma resampler: horizontal blend, line store lookup, vertical blend.
//
//   channel   role        handshake      beat payload
//   samples   sink        valid/ready    u_in[15:0], v_in[15:0], frame_start
//   sited     source      valid/ready    u_out[15:0], v_out[15:0]
//   cfg       sink        valid/ready    index[1:0], data[12:0]
//
// One sample pair per clock is sustained while the result side is ready; a
// result passes through the vertical stage register and the result register
// before it is offered. The line store is read and written once per beat at
// the current column, so the single memory port sets that rate.
// Stalls on the result side back up through the vertical stage to samples.
// Reset clears the column, the first-row flag, the previous samples and the
// registers; the line store holds no reset and needs none.
module chroma_siting_resampler #(
  parameter int unsigned MAX_LINE_WIDTH = csr_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  csr_in_if.sink     samples,
  csr_out_if.source  sited,
  csr_cfg_if.sink    cfg
);
  import csr_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned CMPW = WW + 1;

  csr_offsets_t        offsets;
  logic [WW-1:0]       eff_width;

  // Front state.
  logic [AW-1:0]       col;
  logic [AW-1:0]       col_next;
  logic                first_row;
  logic                first_row_next;
  logic [SAMPLE_W-1:0] prev_u;
  logic [SAMPLE_W-1:0] prev_v;

  // Vertical stage and result register.
  logic                s1_valid;
  logic                s1_vert;
  csr_pair_t           s1_h;
  csr_pair_t           above;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_u;
  logic [SAMPLE_W-1:0] out_v;

  logic                accept;
  logic                s1_adv;
  logic [AW-1:0]       col_eff;
  logic                first_eff;
  logic                line_end;
  csr_pair_t           h_pair;
  logic                vert_eff;

  csr_cfg_regs #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .WW(WW)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .offsets(offsets),
    .eff_width(eff_width)
  );

  // Handshake: the vertical stage moves when the result register is free or drains.
  assign s1_adv        = s1_valid && (!out_valid || sited.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign accept        = samples.valid && samples.ready;

  // Position of this beat, with a frame start restarting the raster.
  always_comb begin
    col_eff   = samples.frame_start ? '0 : col;
    first_eff = samples.frame_start ? 1'b1 : first_row;
    line_end  = (CMPW'(col_eff) + CMPW'(1)) >= CMPW'(eff_width);
    vert_eff  = !first_eff && (offsets.offset_y != '0);
  end

  // Horizontal blend against the previous raw sample of the line.
  always_comb begin
    if (col_eff != '0 && offsets.offset_x != '0) begin
      h_pair.u = blend(prev_u, samples.u_in, offsets.offset_x);
      h_pair.v = blend(prev_v, samples.v_in, offsets.offset_x);
    end else begin
      h_pair.u = samples.u_in;
      h_pair.v = samples.v_in;
    end
  end

  // Column and row tracking.
  always_comb begin
    if (line_end) begin
      col_next       = '0;
      first_row_next = 1'b0;
    end else begin
      col_next       = col_eff + AW'(1);
      first_row_next = first_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
      prev_u    <= '0;
      prev_v    <= '0;
    end else if (accept) begin
      col       <= col_next;
      first_row <= first_row_next;
      prev_u    <= samples.u_in;
      prev_v    <= samples.v_in;
    end
  end

  // The line store swaps the entry above for this beat's filtered pair.
  csr_line_store #(
    .DEPTH(MAX_LINE_WIDTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .en(accept),
    .addr(col_eff),
    .wdata(h_pair),
    .rdata(above)
  );

  // Vertical stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h    <= h_pair;
      s1_vert <= vert_eff;
    end
  end

  // Vertical blend into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (sited.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_vert) begin
        out_u <= blend(above.u, s1_h.u, offsets.offset_y);
        out_v <= blend(above.v, s1_h.v, offsets.offset_y);
      end else begin
        out_u <= s1_h.u;
        out_v <= s1_h.v;
      end
    end
  end

  assign sited.valid = out_valid;
  assign sited.u_out = out_u;
  assign sited.v_out = out_v;

  // The column never leaves the line store.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CMPW'(col) < CMPW'(MAX_LINE_WIDTH))
    else $error("column beyond line store depth");

  // A frame start on a line wider than one sample lands on column one of the first row.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && samples.frame_start && (eff_width > WW'(1))
    |=> first_row && (col == AW'(1)))
    else $error("frame start did not restart the raster");

  // A result only becomes valid after the vertical stage held a beat.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a beat in the vertical stage");

  // A full vertical stage that cannot drain blocks new samples.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !sited.ready |-> !samples.ready)
    else $error("sample taken while the pipeline was blocked");

endmodule

[dv/testbench.sv]
// Self-checking testbench of the chroma siting resampler: scoreboard, drivers, reset and timeout.
`timescale 1ns / 1ps

module testbench;
  import csr_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_LINE_WIDTH_DEF;

  // Predicts every re-sited pair from the accepted samples and checks the result beats.
  class siting_scoreboard;
    logic [OFFSET_W-1:0]     kx;
    logic [OFFSET_W-1:0]     ky;
    logic [LINE_WIDTH_W-1:0] width_reg;
    int unsigned             column;
    bit                      first_row;
    logic [SAMPLE_W-1:0]     prev_u;
    logic [SAMPLE_W-1:0]     prev_v;
    csr_pair_t               line_mem [STORE_DEPTH];
    bit                      written [STORE_DEPTH];
    csr_pair_t               sited_due [$];
    int                      errors;

    function new();
      kx        = '0;
      ky        = '0;
      width_reg = LINE_WIDTH_RST;
      column    = 0;
      first_row = 1'b1;
      prev_u    = '0;
      prev_v    = '0;
      errors    = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Two-tap weighted average with rounding, k in eighths on the older sample.
    function logic [SAMPLE_W-1:0] two_tap(logic [SAMPLE_W-1:0] older,
                                          logic [SAMPLE_W-1:0] newer,
                                          logic [OFFSET_W-1:0] k);
      int unsigned acc;
      acc = int'(k) * int'(older) + (8 - int'(k)) * int'(newer) + 4;
      return 16'(acc >> 3);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OFFSET_X:   kx = data[OFFSET_W-1:0];
        REG_OFFSET_Y:   ky = data[OFFSET_W-1:0];
        REG_LINE_WIDTH: width_reg = data[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    // True when this sample would blend with a line store entry never written.
    function bit reads_blank(bit fs);
      return !fs && !first_row && !written[column];
    endfunction

    // Steps the predicted state by one accepted sample and queues its result.
    function void note_sample(logic [SAMPLE_W-1:0] u, logic [SAMPLE_W-1:0] v, bit fs);
      int unsigned         eff_w;
      int unsigned         col;
      logic [SAMPLE_W-1:0] hu, hv, ou, ov;
      if (fs) begin
        column    = 0;
        first_row = 1'b1;
      end
      eff_w = (width_reg == 0) ? 1 : ((width_reg > STORE_DEPTH) ? STORE_DEPTH : width_reg);
      col   = column % STORE_DEPTH;

      // Horizontal pass against the previous raw sample.
      if (col != 0 && kx != 0) begin
        hu = two_tap(prev_u, u, kx);
        hv = two_tap(prev_v, v, kx);
      end else begin
        hu = u;
        hv = v;
      end

      // Vertical pass against the filtered sample one line up.
      if (!first_row && ky != 0) begin
        ou = two_tap(line_mem[col].u, hu, ky);
        ov = two_tap(line_mem[col].v, hv, ky);
      end else begin
        ou = hu;
        ov = hv;
      end

      line_mem[col] = '{v: hv, u: hu};
      written[col]  = 1'b1;
      prev_u        = u;
      prev_v        = v;
      if (col + 1 >= eff_w) begin
        column    = 0;
        first_row = 1'b0;
      end else begin
        column = col + 1;
      end
      sited_due.push_back('{v: ov, u: ou});
    endfunction

    function void check_sited(logic [SAMPLE_W-1:0] u, logic [SAMPLE_W-1:0] v);
      csr_pair_t want;
      if (sited_due.size() == 0) begin
        $error("unexpected result beat: u_out=%h v_out=%h", u, v);
        errors++;
        return;
      end
      want = sited_due.pop_front();
      if (u !== want.u) begin
        $error("u_out mismatch: expected %h, actual %h", want.u, u);
        errors++;
      end
      if (v !== want.v) begin
        $error("v_out mismatch: expected %h, actual %h", want.v, v);
        errors++;
      end
    endfunction

    function int pending();
      return sited_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  csr_in_if  samples_if();
  csr_out_if sited_if();
  csr_cfg_if cfg_if();

  chroma_siting_resampler u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .sited   (sited_if),
    .cfg     (cfg_if)
  );

  siting_scoreboard sb;
  int unsigned      samples_sent;
  bit               calm;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               hold_request;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit on the whole run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, then always ready.
  initial begin
    sited_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        sited_if.ready = 1'b0;
        repeat (60) @(negedge clk);
        hold_request = 1'b0;
      end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
        sited_if.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        sited_if.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Result beats are taken at the rising edge.
  always @(posedge clk) begin
    if (!rst && sited_if.valid === 1'b1 && sited_if.ready)
      sb.check_sited(sited_if.u_out, sited_if.v_out);
  end

  // Offers one sample until it is taken; valid stays high on return.
  task automatic send_sample(input logic [15:0] u, input logic [15:0] v, input bit fs);
    if (sb.reads_blank(fs)) fs = 1'b1;
    samples_if.valid       = 1'b1;
    samples_if.u_in        = u;
    samples_if.v_in        = v;
    samples_if.frame_start = fs;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_sample(u, v, fs);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic pause_samples(input int cycles);
    samples_if.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Writes one register; the caller lowers valid after the last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Waits until every queued result has come back, then lets the pipeline settle.
  task automatic wait_idle();
    samples_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offset data: extremes often, and junk in the upper bits now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    logic [OFFSET_W-1:0] k;
    case ($urandom_range(0, 3))
      0:       k = 3'd0;
      1:       k = 3'd7;
      default: k = 3'($urandom_range(0, 7));
    endcase
    if ($urandom_range(0, 3) == 0)
      return {10'($urandom_range(0, 1023)), k};
    return {10'd0, k};
  endfunction

  // Short directed pass over the extremes and the line width corner cases.
  task automatic directed_checks();
    int i;
    // Both directions bypassed at reset.
    send_sample(16'h0000, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'h0000, 1'b0);

    // Lightest horizontal and heaviest vertical weight on a three-wide line.
    wait_idle();
    write_reg(REG_OFFSET_X, 13'd1);
    write_reg(REG_OFFSET_Y, 13'd7);
    write_reg(REG_LINE_WIDTH, 13'd3);
    cfg_if.valid = 1'b0;
    for (i = 0; i < 6; i++)
      send_sample((i % 2) ? 16'hFFFF : 16'h0000, (i % 2) ? 16'h0000 : 16'hFFFF, i == 0);

    // A zero width acts as one sample per line.
    wait_idle();
    write_reg(REG_OFFSET_X, 13'd7);
    write_reg(REG_OFFSET_Y, 13'd1);
    write_reg(REG_LINE_WIDTH, 13'd0);
    cfg_if.valid = 1'b0;
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h8001, 16'h7FFE, 1'b0);

    // Widths beyond the line store saturate; then the largest legal width.
    wait_idle();
    write_reg(REG_LINE_WIDTH, 13'h1FFF);
    cfg_if.valid = 1'b0;
    for (i = 0; i < 4; i++) send_sample(pick_sample(), pick_sample(), i == 0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 13'd4096);
    cfg_if.valid = 1'b0;
    for (i = 0; i < 3; i++) send_sample(pick_sample(), pick_sample(), i == 0);

    // Width lowered below the current column ends the line after the next sample.
    wait_idle();
    write_reg(REG_OFFSET_X, 13'd0);
    write_reg(REG_LINE_WIDTH, 13'd5);
    cfg_if.valid = 1'b0;
    for (i = 0; i < 4; i++) send_sample(pick_sample(), pick_sample(), i == 0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 13'd2);
    cfg_if.valid = 1'b0;
    for (i = 0; i < 3; i++) send_sample(pick_sample(), pick_sample(), 1'b0);
  endtask

  // One random phase: new settings, then rows of random samples.
  task automatic random_phase(input int phase_idx);
    int                      n_items;
    int                      i;
    bit                      restart;
    bit                      fs;
    logic [CFG_DATA_W-1:0]   w;
    wait_idle();
    if (phase_idx == 0 || $urandom_range(0, 1)) write_reg(REG_OFFSET_X, pick_offset());
    if (phase_idx == 0 || $urandom_range(0, 1)) write_reg(REG_OFFSET_Y, pick_offset());
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 2))
          0:       w = 13'd0;
          1:       w = 13'd4096;
          default: w = 13'($urandom_range(4097, 8191));
        endcase
        n_items = 12;
      end
      1, 2, 3: begin
        w       = 13'($urandom_range(17, 64));
        n_items = $urandom_range(60, 150);
      end
      default: begin
        w       = 13'($urandom_range(1, 16));
        n_items = $urandom_range(30, 90);
      end
    endcase
    write_reg(REG_LINE_WIDTH, w);
    cfg_if.valid = 1'b0;

    tx_idle_on = $urandom_range(0, 2) != 0;
    rx_idle_on = $urandom_range(0, 2) != 0;
    if (phase_idx == 1) hold_request = 1'b1;
    restart = $urandom_range(0, 1);

    for (i = 0; i < n_items; i++) begin
      if (!calm && tx_idle_on && $urandom_range(0, 4) == 0)
        pause_samples($urandom_range(1, 11));
      fs = (i == 0 && restart) || $urandom_range(0, 59) == 0;
      send_sample(pick_sample(), pick_sample(), fs);
    end
    samples_if.valid = 1'b0;
  endtask

  // Reset, directed pass, random phases, drain and verdict.
  initial begin
    int phase_idx;
    sb                     = new();
    samples_sent           = 0;
    calm                   = 1'b0;
    tx_idle_on             = 1'b0;
    rx_idle_on             = 1'b0;
    hold_request           = 1'b0;
    rst                    = 1'b1;
    samples_if.valid       = 1'b0;
    samples_if.u_in        = '0;
    samples_if.v_in        = '0;
    samples_if.frame_start = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_OFFSET_X;
    cfg_if.data            = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_checks();

    phase_idx = 0;
    while (samples_sent < 715) begin
      if (samples_sent >= 590) calm = 1'b1;
      random_phase(phase_idx);
      phase_idx++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/csr_pkg.sv
hw/rtl/csr_ifs.sv
hw/rtl/csr_cfg_regs.sv
hw/rtl/csr_line_store.sv
hw/rtl/chroma_siting_resampler.sv
dv/testbench.sv
